>>> design/cbz_pkg.sv
// Shared constants, types and helpers for the cubic curve evaluator.
package cbz_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int OUT_WIDTH       = 48;
    localparam int T_IN_WIDTH      = 17;
    localparam int OP_WIDTH        = 2;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int NUM_STAGES      = 7;
    localparam int NUM_CTRL        = 4;

    typedef logic [OP_WIDTH-1:0]      op_t;
    typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;
    typedef logic [NUM_STAGES-1:0]    stage_en_t;

    localparam op_t OP_POSITION = 2'd0;
    localparam op_t OP_FIRST    = 2'd1;
    localparam op_t OP_SECOND   = 2'd2;

    localparam cfg_idx_t REG_CTRL0_X = 3'd0;
    localparam cfg_idx_t REG_CTRL0_Y = 3'd1;
    localparam cfg_idx_t REG_CTRL1_X = 3'd2;
    localparam cfg_idx_t REG_CTRL1_Y = 3'd3;
    localparam cfg_idx_t REG_CTRL2_X = 3'd4;
    localparam cfg_idx_t REG_CTRL2_Y = 3'd5;
    localparam cfg_idx_t REG_CTRL3_X = 3'd6;
    localparam cfg_idx_t REG_CTRL3_Y = 3'd7;

    // Signed basis weight, wide enough for t^3 at full scale plus sign
    function automatic int weight_width(input int tf);
        return 3 * tf + 2;
    endfunction

endpackage

>>> design/cbz_if.sv
// Channel interfaces: sample input, result output and register write.
interface cbz_in_if
    import cbz_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OP_WIDTH-1:0]   operation;
    logic [T_IN_WIDTH-1:0] t_param;

    modport source (output valid, output operation, output t_param, input ready);
    modport sink   (input valid, input operation, input t_param, output ready);
endinterface

interface cbz_out_if
    import cbz_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [OUT_WIDTH-1:0] out_x;
    logic signed [OUT_WIDTH-1:0] out_y;

    modport source (output valid, output out_x, output out_y, input ready);
    modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

interface cbz_cfg_if
    import cbz_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_WIDTH-1:0] index;
    logic [COORD_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/cbz_regs.sv
// Control point register file.
module cbz_regs
    import cbz_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  cfg_idx_t                      wr_index,
    input  logic        [COORD_WIDTH-1:0] wr_data,
    output logic signed [COORD_WIDTH-1:0] ctrl_x [NUM_CTRL],
    output logic signed [COORD_WIDTH-1:0] ctrl_y [NUM_CTRL]
);

    logic signed [COORD_WIDTH-1:0] ctrl_x_reg [NUM_CTRL];
    logic signed [COORD_WIDTH-1:0] ctrl_y_reg [NUM_CTRL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CTRL; i++)
            begin
                ctrl_x_reg[i] <= '0;
                ctrl_y_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CTRL0_X: ctrl_x_reg[0] <= $signed(wr_data);
                REG_CTRL0_Y: ctrl_y_reg[0] <= $signed(wr_data);
                REG_CTRL1_X: ctrl_x_reg[1] <= $signed(wr_data);
                REG_CTRL1_Y: ctrl_y_reg[1] <= $signed(wr_data);
                REG_CTRL2_X: ctrl_x_reg[2] <= $signed(wr_data);
                REG_CTRL2_Y: ctrl_y_reg[2] <= $signed(wr_data);
                REG_CTRL3_X: ctrl_x_reg[3] <= $signed(wr_data);
                REG_CTRL3_Y: ctrl_y_reg[3] <= $signed(wr_data);
                default: ;
            endcase
        end
    end

    assign ctrl_x = ctrl_x_reg;
    assign ctrl_y = ctrl_y_reg;

endmodule

>>> design/cbz_weights.sv
// Stages 1 to 3: clamp t, form r, the squares and the four basis weights.
module cbz_weights
    import cbz_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  stage_en_t                                   en,
    input  op_t                                         operation,
    input  logic [T_IN_WIDTH-1:0]                       t_param,
    output logic signed [weight_width(T_FRAC_BITS)-1:0] weight [NUM_CTRL],
    output op_t                                         op
);

    localparam int TW = T_FRAC_BITS + 1;
    localparam int PW = 2 * T_FRAC_BITS + 1;
    localparam int WW = weight_width(T_FRAC_BITS);
    localparam logic [TW-1:0] ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    // stage 1
    logic [T_IN_WIDTH+TW-1:0] t_ext;
    logic [TW-1:0]            t_mask;
    logic [TW-1:0]            t_next;
    logic [TW-1:0]            t1_reg;
    logic [TW-1:0]            r1_reg;
    op_t                      op1_reg;

    always_comb
    begin
        t_ext  = (T_IN_WIDTH + TW)'(t_param);
        t_mask = t_ext[TW-1:0];
        t_next = (t_mask > ONE) ? ONE : t_mask;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t1_reg  <= t_next;
            r1_reg  <= ONE - t_next;
            op1_reg <= operation;
        end
    end

    // stage 2
    logic [PW-1:0] rr_reg;
    logic [PW-1:0] rt_reg;
    logic [PW-1:0] tt_reg;
    logic [TW-1:0] t2_reg;
    logic [TW-1:0] r2_reg;
    op_t           op2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rr_reg  <= PW'(r1_reg) * PW'(r1_reg);
            rt_reg  <= PW'(r1_reg) * PW'(t1_reg);
            tt_reg  <= PW'(t1_reg) * PW'(t1_reg);
            t2_reg  <= t1_reg;
            r2_reg  <= r1_reg;
            op2_reg <= op1_reg;
        end
    end

    // stage 3
    logic [WW-1:0]        cube [NUM_CTRL];
    logic signed [WW-1:0] rr_s;
    logic signed [WW-1:0] rt_s;
    logic signed [WW-1:0] tt_s;
    logic signed [WW-1:0] t_s;
    logic signed [WW-1:0] r_s;
    logic signed [WW-1:0] w_next [NUM_CTRL];
    logic signed [WW-1:0] w3_reg [NUM_CTRL];
    op_t                  op3_reg;

    always_comb
    begin
        cube[0] = WW'(rr_reg) * WW'(r2_reg);
        cube[1] = WW'(rr_reg) * WW'(t2_reg);
        cube[2] = WW'(tt_reg) * WW'(r2_reg);
        cube[3] = WW'(tt_reg) * WW'(t2_reg);
        rr_s = $signed(WW'(rr_reg));
        rt_s = $signed(WW'(rt_reg));
        tt_s = $signed(WW'(tt_reg));
        t_s  = $signed(WW'(t2_reg));
        r_s  = $signed(WW'(r2_reg));
        case (op2_reg)
            OP_POSITION:
            begin
                for (int i = 0; i < NUM_CTRL; i++)
                begin
                    w_next[i] = $signed(cube[i]);
                end
            end
            OP_FIRST:
            begin
                w_next[0] = -((rr_s <<< 1) + rr_s);
                w_next[1] = rr_s - (rt_s <<< 1);
                w_next[2] = (rt_s <<< 1) - tt_s;
                w_next[3] = (tt_s <<< 1) + tt_s;
            end
            OP_SECOND:
            begin
                w_next[0] = (r_s <<< 2) + (r_s <<< 1);
                w_next[1] = (t_s <<< 1) - (r_s <<< 2);
                w_next[2] = (r_s <<< 1) - (t_s <<< 2);
                w_next[3] = (t_s <<< 2) + (t_s <<< 1);
            end
            default:
            begin
                // unused code: zero weights give a zero result
                for (int i = 0; i < NUM_CTRL; i++)
                begin
                    w_next[i] = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            w3_reg  <= w_next;
            op3_reg <= op2_reg;
        end
    end

    assign weight = w3_reg;
    assign op     = op3_reg;

endmodule

>>> design/cbz_dot.sv
// Stages 4 to 7 for one axis: split products, sums, rounding and scaling.
module cbz_dot
    import cbz_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                                        clk,
    input  stage_en_t                                   en,
    input  op_t                                         op,
    input  logic signed [COORD_WIDTH-1:0]               coef   [NUM_CTRL],
    input  logic signed [weight_width(T_FRAC_BITS)-1:0] weight [NUM_CTRL],
    output logic signed [OUT_WIDTH-1:0]                 value
);

    localparam int WW    = weight_width(T_FRAC_BITS);
    localparam int LO_W  = WW / 2;
    localparam int HI_W  = WW - LO_W;
    localparam int PL_W  = COORD_WIDTH + LO_W + 1;
    localparam int PH_W  = COORD_WIDTH + HI_W;
    localparam int SL_W  = PL_W + 2;
    localparam int SH_W  = PH_W + 2;
    localparam int AW    = COORD_WIDTH + WW + 3;
    localparam int SH_POS = 3 * T_FRAC_BITS;
    localparam int SH_FST = 2 * T_FRAC_BITS;
    localparam int SH_SND = T_FRAC_BITS;
    localparam logic signed [AW-1:0] HALF_POS = AW'(1) <<< (SH_POS - 1);
    localparam logic signed [AW-1:0] HALF_FST = AW'(1) <<< (SH_FST - 1);
    localparam logic signed [AW-1:0] HALF_SND = AW'(1) <<< (SH_SND - 1);

    // stage 4: each weight in an unsigned low half and a signed high half
    logic signed [PL_W-1:0] p_lo_next [NUM_CTRL];
    logic signed [PH_W-1:0] p_hi_next [NUM_CTRL];
    logic signed [PL_W-1:0] p_lo_reg  [NUM_CTRL];
    logic signed [PH_W-1:0] p_hi_reg  [NUM_CTRL];
    op_t                    op4_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_CTRL; i++)
        begin
            p_lo_next[i] = coef[i] * $signed({1'b0, weight[i][LO_W-1:0]});
            p_hi_next[i] = coef[i] * $signed(weight[i][WW-1:LO_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
            op4_reg  <= op;
        end
    end

    // stage 5
    logic signed [SL_W-1:0] s_lo_reg;
    logic signed [SH_W-1:0] s_hi_reg;
    op_t                    op5_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s_lo_reg <= SL_W'(p_lo_reg[0]) + SL_W'(p_lo_reg[1])
                      + SL_W'(p_lo_reg[2]) + SL_W'(p_lo_reg[3]);
            s_hi_reg <= SH_W'(p_hi_reg[0]) + SH_W'(p_hi_reg[1])
                      + SH_W'(p_hi_reg[2]) + SH_W'(p_hi_reg[3]);
            op5_reg  <= op4_reg;
        end
    end

    // stage 6: join halves, add rounding bias
    logic signed [AW-1:0] half;
    logic signed [AW-1:0] acc_reg;
    op_t                  op6_reg;

    always_comb
    begin
        case (op5_reg)
            OP_FIRST:  half = HALF_FST;
            OP_SECOND: half = HALF_SND;
            default:   half = HALF_POS;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            acc_reg <= AW'(s_lo_reg) + (AW'(s_hi_reg) <<< LO_W) + half;
            op6_reg <= op5_reg;
        end
    end

    // stage 7: drop fraction bits for the degree of the result
    logic signed [AW-1:0]        scaled;
    logic signed [OUT_WIDTH-1:0] value_reg;

    always_comb
    begin
        case (op6_reg)
            OP_FIRST:  scaled = acc_reg >>> SH_FST;
            OP_SECOND: scaled = acc_reg >>> SH_SND;
            default:   scaled = acc_reg >>> SH_POS;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            value_reg <= OUT_WIDTH'(scaled);
        end
    end

    assign value = value_reg;

endmodule

>>> design/cubic_bezier_point_and_derivatives.sv
// Top level: 2-D cubic curve evaluator for position and first two derivatives.
//
//   channel  dir  beat payload                      handshake
//   sample   in   operation[1:0], t_param[16:0]     valid/ready
//   result   out  out_x[47:0], out_y[47:0]          valid/ready
//   cfg      in   index[2:0], data[COORD_WIDTH-1:0] valid/ready, ready tied high
//
// Seven register stages; a new beat can enter every cycle unless the pipeline
// is full behind a stalled result. The depth is set by the two multiply stages
// for the basis weights and the split 32 by 25 bit product stage per axis.
// Reset empties the pipeline and clears all control points to zero.
// Each stage holds while its successor is full and stalled; an empty stage
// always loads, so bubbles close up behind a stalled result.
module cubic_bezier_point_and_derivatives
    import cbz_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    cbz_in_if.sink          sample,
    cbz_out_if.source       result,
    cbz_cfg_if.sink         cfg
);

    localparam int WW = weight_width(T_FRAC_BITS);

    // control point registers; the user must write them only while idle, not enforced here
    logic signed [COORD_WIDTH-1:0] ctrl_x [NUM_CTRL];
    logic signed [COORD_WIDTH-1:0] ctrl_y [NUM_CTRL];

    assign cfg.ready = 1'b1;

    cbz_regs #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .ctrl_x   (ctrl_x),
        .ctrl_y   (ctrl_y)
    );

    // per-stage occupancy and advance chain
    stage_en_t v_reg;
    stage_en_t v_next;
    stage_en_t adv;
    logic      in_fire;
    logic      out_fire;

    always_comb
    begin
        // a stage advances when it is empty or its successor advances
        adv[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || result.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
        v_next[0] = adv[0] ? sample.valid : v_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            v_next[i] = adv[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign sample.ready = adv[0];
    assign result.valid = v_reg[NUM_STAGES-1];
    assign in_fire      = sample.valid && sample.ready;
    assign out_fire     = result.valid && result.ready;

    // stages 1 to 3: shared basis weights for both axes
    logic signed [WW-1:0] weight [NUM_CTRL];
    op_t                  op_w;

    cbz_weights #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_weights (
        .clk       (clk),
        .en        (adv),
        .operation (sample.operation),
        .t_param   (sample.t_param),
        .weight    (weight),
        .op        (op_w)
    );

    // stages 4 to 7: one weighted sum per axis
    logic signed [OUT_WIDTH-1:0] x_value;
    logic signed [OUT_WIDTH-1:0] y_value;

    cbz_dot #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_dot_x (
        .clk    (clk),
        .en     (adv),
        .op     (op_w),
        .coef   (ctrl_x),
        .weight (weight),
        .value  (x_value)
    );

    cbz_dot #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_dot_y (
        .clk    (clk),
        .en     (adv),
        .op     (op_w),
        .coef   (ctrl_y),
        .weight (weight),
        .value  (y_value)
    );

    assign result.out_x = x_value;
    assign result.out_y = y_value;

    // an accepted beat occupies the first stage on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> v_reg[0])
        else $error("accepted beat missing from first stage");

    // beats in flight change only by what enters and leaves
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(v_reg) == $past($countones(v_reg))
                  + int'($past(in_fire)) - int'($past(out_fire))))
        else $error("pipeline occupancy lost or duplicated a beat");

    // a full pipeline behind a stalled result takes nothing new
    assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg && !result.ready) |-> !sample.ready)
        else $error("input accepted while pipeline full and stalled");

endmodule
